// File: hdl/row_pattern_matcher_macros.svh
// assertion helpers for the row pattern matcher
`ifndef ROW_PATTERN_MATCHER_MACROS_SVH
`define ROW_PATTERN_MATCHER_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every edge out of reset
`define RPM_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error("rpm assertion failed");
// condition must never be true out of reset
`define RPM_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
        else $error("rpm forbidden condition seen");
`else
`define RPM_ASSERT(lbl, clk_s, rstn_s, prop)
`define RPM_ASSERT_NEVER(lbl, clk_s, rstn_s, cond)
`endif

`endif

// File: hdl/rpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rpm_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int MAX_COLUMNS_DEF = 16;
    localparam int MAX_ROWS_DEF    = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_CHARS  = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1,
        CFG_ROW_LENGTH     = 2'd2
    } rpm_cfg_idx_t;

    typedef struct packed {
        logic [63:0] pattern_chars;
        logic [3:0]  pattern_length;
        logic [4:0]  row_length;
    } rpm_cfg_t;

    // one classified character on its way to the back end
    typedef struct packed {
        logic       hit;
        logic [3:0] row;
        logic [3:0] column;
        logic       last;
    } rpm_ev_t;

endpackage

`default_nettype wire

// File: hdl/rpm_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface rpm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last_of_text;

    modport source (output valid, output ch, output last_of_text, input ready);
    modport sink (input valid, input ch, input last_of_text, output ready);
endinterface

interface rpm_out_if;
    logic        valid;
    logic        ready;
    logic        match;
    logic [3:0]  match_row;
    logic [3:0]  match_column;
    logic [15:0] match_count;
    logic        none_found;

    modport source (output valid, output match, output match_row, output match_column,
                    output match_count, output none_found, input ready);
    modport sink (input valid, input match, input match_row, input match_column,
                  input match_count, input none_found, output ready);
endinterface

interface rpm_cfg_if;
    import rpm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/rpm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rpm_front #(
    parameter int MAX_PATTERN = rpm_pkg::MAX_PATTERN_DEF,
    parameter int MAX_COLUMNS = rpm_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = rpm_pkg::MAX_ROWS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    rpm_in_if.sink                text_in,
    input  wire rpm_pkg::rpm_cfg_t cfg_regs,
    output rpm_pkg::rpm_ev_t      ev,
    output logic                  ev_valid,
    input  wire logic             ev_ready
);
    import rpm_pkg::*;

    localparam int PIdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int ColW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int PosW  = (ColW + 1 > 4) ? ColW + 1 : 4;
    localparam int LenW  = (ColW + 1 > 5) ? ColW + 1 : 5;
    localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RowOW = (RowW > 4) ? RowW : 4;

    logic [7:0]      win_reg [MAX_PATTERN];
    logic [7:0]      win_next [MAX_PATTERN];
    logic [ColW-1:0] col_reg, col_next;
    logic [RowW-1:0] row_reg, row_next;

    logic [3:0]       plen;
    logic [LenW-1:0]  rlen;
    logic [PosW-1:0]  pos;
    logic [PosW-1:0]  start;
    logic [PIdxW-1:0] pidx;
    logic [RowOW-1:0] row_ext;
    logic             hit;
    logic             row_end;
    logic             accept;

    assign accept        = text_in.valid && text_in.ready;
    assign text_in.ready = ev_ready;
    assign ev_valid      = text_in.valid;

    always_comb
    begin
        plen = cfg_regs.pattern_length;
        if (plen == 4'd0)
        begin
            plen = 4'd1;
        end
        else if (plen > 4'(MAX_PATTERN))
        begin
            plen = 4'(MAX_PATTERN);
        end

        rlen = LenW'(cfg_regs.row_length);
        if (rlen == '0)
        begin
            rlen = LenW'(1);
        end
        else if (rlen > LenW'(MAX_COLUMNS))
        begin
            rlen = LenW'(MAX_COLUMNS);
        end

        // newest character sits at slot zero
        win_next[0] = text_in.ch;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            win_next[k] = win_reg[k-1];
        end

        pos  = PosW'(col_reg) + PosW'(1);
        hit  = (pos >= PosW'(plen));
        pidx = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (4'(i) < plen)
            begin
                pidx = PIdxW'(plen - 4'(i) - 4'd1);
                if (win_next[pidx] != cfg_regs.pattern_chars[8*i +: 8])
                begin
                    hit = 1'b0;
                end
            end
        end
        start   = pos - PosW'(plen);
        row_ext = RowOW'(row_reg);

        ev.hit    = hit;
        ev.row    = hit ? row_ext[3:0] : 4'd0;
        ev.column = hit ? start[3:0] : 4'd0;
        ev.last   = text_in.last_of_text;

        // row ends once the column reaches the last one of the row
        row_end  = (LenW'(pos) >= rlen);
        col_next = col_reg + ColW'(1);
        row_next = row_reg;
        if (text_in.last_of_text)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (row_end)
        begin
            col_next = '0;
            row_next = (row_reg == RowW'(MAX_ROWS - 1)) ? '0 : row_reg + RowW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                win_reg[k] <= '0;
            end
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                win_reg[k] <= text_in.last_of_text ? 8'd0 : win_next[k];
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/rpm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

`include "row_pattern_matcher_macros.svh"

module rpm_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire rpm_pkg::rpm_ev_t push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output rpm_pkg::rpm_ev_t      pop_data
);
    import rpm_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    rpm_ev_t       mem [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]   level_reg, level_next;
    logic            push, pop;

    assign push_ready = (level_reg != (PtrW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (level_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + (PtrW+1)'(1);
        end
        else if (pop && !push)
        begin
            level_next = level_reg - (PtrW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PtrW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PtrW'(1);
            end
            level_reg <= level_next;
        end
    end

    `RPM_ASSERT_NEVER(a_level_in_range, clk, rst_n, level_reg > (PtrW+1)'(QUEUE_DEPTH))
    `RPM_ASSERT(a_push_shows_up, clk, rst_n, push && level_reg == '0 |=> pop_valid)

endmodule

`default_nettype wire

// File: hdl/rpm_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "row_pattern_matcher_macros.svh"

module rpm_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             ev_valid,
    output logic                  ev_ready,
    input  wire rpm_pkg::rpm_ev_t ev,
    rpm_out_if.source             result_out
);
    import rpm_pkg::*;

    logic        out_valid_reg;
    logic        match_reg;
    logic [3:0]  row_reg;
    logic [3:0]  column_reg;
    logic [15:0] out_count_reg;
    logic        none_reg;
    logic [15:0] count_reg, count_next;
    logic        found_reg, found_next;
    logic        ev_fire;

    assign ev_ready = !out_valid_reg || result_out.ready;
    assign ev_fire  = ev_valid && ev_ready;

    assign result_out.valid        = out_valid_reg;
    assign result_out.match        = match_reg;
    assign result_out.match_row    = row_reg;
    assign result_out.match_column = column_reg;
    assign result_out.match_count  = out_count_reg;
    assign result_out.none_found   = none_reg;

    always_comb
    begin
        count_next = count_reg;
        found_next = found_reg;
        if (ev.hit)
        begin
            found_next = 1'b1;
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_fire)
        begin
            match_reg     <= ev.hit;
            row_reg       <= ev.row;
            column_reg    <= ev.column;
            out_count_reg <= count_next;
            none_reg      <= ev.last && !found_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (ev_fire)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= ev.last ? 16'd0 : count_next;
                found_reg     <= ev.last ? 1'b0 : found_next;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `RPM_ASSERT(a_match_counted, clk, rst_n, out_valid_reg && match_reg |-> out_count_reg != 16'd0)
    `RPM_ASSERT(a_none_excl, clk, rst_n, out_valid_reg && none_reg |-> !match_reg && !found_reg)
    `RPM_ASSERT(a_count_grows, clk, rst_n, !(ev_fire && ev.last) |=> count_reg >= $past(count_reg))

endmodule

`default_nettype wire

// File: hdl/row_pattern_matcher.sv
// a result is registered first in its queue entry, then in the output reg, before it is offered
// throughput: one character per cycle while results are taken, every character gives one result
// the front keeps the character window and row/column position, the back keeps the match count
// a two-entry queue between them lets a stalled result side hold back the front by itself
// reset (async, active low): window, position, count and queue cleared, registers to defaults
`timescale 1ns / 1ps
`default_nettype none

module row_pattern_matcher #(
    parameter int MAX_PATTERN = rpm_pkg::MAX_PATTERN_DEF,
    parameter int MAX_COLUMNS = rpm_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = rpm_pkg::MAX_ROWS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rpm_cfg_if.sink   cfg,
    rpm_in_if.sink    text_in,
    rpm_out_if.source result_out
);
    import rpm_pkg::*;

    // configuration registers; the user must write them only while no text is in flight (not enforced)
    rpm_cfg_t cfg_reg;

    // front to queue
    rpm_ev_t  fe_ev;
    logic     fe_valid;
    logic     fe_ready;

    // queue to back
    rpm_ev_t  q_ev;
    logic     q_valid;
    logic     q_ready;

    // every config transfer is taken at once
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_chars  <= 64'd0;
            cfg_reg.pattern_length <= 4'd1;
            cfg_reg.row_length     <= 5'd16;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_PATTERN_CHARS:  cfg_reg.pattern_chars  <= cfg.data;
                CFG_PATTERN_LENGTH: cfg_reg.pattern_length <= cfg.data[3:0];
                CFG_ROW_LENGTH:     cfg_reg.row_length     <= cfg.data[4:0];
                // writes beyond the register list are dropped
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front: shift in the character, compare against the pattern, track row and column
    rpm_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .cfg_regs (cfg_reg),
        .ev       (fe_ev),
        .ev_valid (fe_valid),
        .ev_ready (fe_ready)
    );

    // short queue decouples the classify side from the result side
    rpm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_data  (fe_ev),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_ev)
    );

    // back: saturating count, found flag and the registered result
    rpm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ev_valid   (q_valid),
        .ev_ready   (q_ready),
        .ev         (q_ev),
        .result_out (result_out)
    );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rpm_pkg::*;

    // cycles without any transfer on any channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    // pause after the last result before touching the registers
    localparam int SETTLE_CYCLES = 3;

    typedef struct {
        bit        match;
        bit [3:0]  row;
        bit [3:0]  column;
        bit [15:0] count;
        bit        none_found;
    } match_result_t;

    logic clk = 1'b0;
    logic rst_n;

    rpm_cfg_if cfg_if ();
    rpm_in_if  text_if ();
    rpm_out_if res_if ();

    row_pattern_matcher dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_if),
        .text_in    (text_if),
        .result_out (res_if)
    );

    always #6 clk = ~clk;

    // register copies as the block should hold them
    logic [63:0] pat_chars = '0;
    logic [3:0]  pat_len = 4'd1;
    logic [4:0]  row_len = 5'd16;

    // scan state of the text in progress
    logic [7:0]  text_window [MAX_PATTERN_DEF];
    int          col_pos = 0;
    int          row_pos = 0;
    logic [15:0] match_total = '0;
    bit          seen_match = 1'b0;

    match_result_t pending_matches [$];
    int failures = 0;
    int idle_cycles = 0;

    // idling knobs for the sender and the receiver process
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int rx_hold_request = 0;

    initial begin
        foreach (text_window[i])
            text_window[i] = '0;
    end

    // back to the start of a fresh text
    function automatic void clear_text();
        foreach (text_window[i])
            text_window[i] = '0;
        col_pos = 0;
        row_pos = 0;
        match_total = '0;
        seen_match = 1'b0;
    endfunction

    // predicted result for one character, advancing the scan state
    function automatic match_result_t scan_char(logic [7:0] c, logic last);
        int plen;
        int rlen;
        int start;
        int i;
        bit hit;
        match_result_t r;
        plen = pat_len;
        rlen = row_len;
        // zero lengths act as one, oversized lengths clamp to the maximum
        if (plen < 1)
            plen = 1;
        if (plen > MAX_PATTERN_DEF)
            plen = MAX_PATTERN_DEF;
        if (rlen < 1)
            rlen = 1;
        if (rlen > MAX_COLUMNS_DEF)
            rlen = MAX_COLUMNS_DEF;
        // newest character sits at the front of the window
        for (i = MAX_PATTERN_DEF - 1; i > 0; i--)
            text_window[i] = text_window[i - 1];
        text_window[0] = c;
        hit = 1'b0;
        start = 0;
        // only a pattern that fits inside the current row can match
        if (col_pos + 1 >= plen) begin
            hit = 1'b1;
            for (i = 0; i < plen; i++)
                if (text_window[plen - 1 - i] != pat_chars[8 * i +: 8])
                    hit = 1'b0;
            start = col_pos + 1 - plen;
        end
        if (hit) begin
            seen_match = 1'b1;
            if (match_total != COUNT_MAX)
                match_total++;
        end
        r.match = hit;
        r.row = hit ? row_pos[3:0] : 4'd0;
        r.column = hit ? start[3:0] : 4'd0;
        r.count = match_total;
        r.none_found = last && !seen_match;
        // advance position; a shortened row ends as soon as the column reaches it
        if (last)
            clear_text();
        else if (col_pos + 1 >= rlen) begin
            col_pos = 0;
            row_pos = (row_pos + 1) % MAX_ROWS_DEF;
        end
        else
            col_pos++;
        return r;
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
            failures++;
        end
    endfunction

    // predict on every character transfer, then check every result transfer
    always @(posedge clk) begin
        match_result_t want;
        if (rst_n) begin
            if (text_if.valid && text_if.ready)
                pending_matches.push_back(scan_char(text_if.ch, text_if.last_of_text));
            if (res_if.valid && res_if.ready) begin
                if (pending_matches.size() == 0) begin
                    $display("%0t ns: unexpected result expected none actual match=%0h count=%0h",
                             $time, res_if.match, res_if.match_count);
                    failures++;
                end
                else begin
                    want = pending_matches.pop_front();
                    compare_field("match", want.match, res_if.match);
                    compare_field("match_row", want.row, res_if.match_row);
                    compare_field("match_column", want.column, res_if.match_column);
                    compare_field("match_count", want.count, res_if.match_count);
                    compare_field("none_found", want.none_found, res_if.none_found);
                end
            end
        end
    end

    // watchdog on total silence across all three channels
    always @(posedge clk) begin
        if (rst_n) begin
            if ((text_if.valid && text_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: watchdog expired with %0d results outstanding",
                         $time, pending_matches.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result receiver: random stalls, plus a long hold-off on request
    initial begin
        int stall;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (rx_hold_request > 0) begin
                res_if.ready <= 1'b0;
                repeat (rx_hold_request) @(posedge clk);
                rx_hold_request = 0;
            end
            else begin
                stall = rx_idle_en ? $urandom_range(0, 10) : 0;
                if (stall > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            res_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(res_if.valid && res_if.ready));
        end
    end

    // one character transfer; valid stays up so back-to-back characters need no gap
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            text_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_if.valid <= 1'b1;
        text_if.ch <= c;
        text_if.last_of_text <= last;
        do
            @(posedge clk);
        while (!text_if.ready);
    endtask

    // stop sending and let every outstanding result drain
    task automatic wait_idle();
        text_if.valid <= 1'b0;
        // wait for the clock so the predictor has logged the final character transfer
        @(posedge clk);
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input rpm_cfg_idx_t idx, input logic [63:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (idx)
            CFG_PATTERN_CHARS:  pat_chars = value;
            CFG_PATTERN_LENGTH: pat_len = value[3:0];
            CFG_ROW_LENGTH:     row_len = value[4:0];
            default:            ;
        endcase
    endtask

    // all three registers back to back, only while idle
    task automatic set_config(input logic [63:0] chars, input logic [63:0] plen_data,
                              input logic [63:0] rlen_data);
        write_reg(CFG_PATTERN_CHARS, chars);
        write_reg(CFG_PATTERN_LENGTH, plen_data);
        write_reg(CFG_ROW_LENGTH, rlen_data);
        cfg_if.valid <= 1'b0;
    endtask

    // power-on registers: single zero byte pattern, 16 column rows
    task automatic test_reset_defaults();
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);
        // text without any match flags none found
        send_char(8'h7E, 1'b1);
        wait_idle();
    endtask

    // three character pattern on 4 column rows, including occurrences split across a row end
    task automatic test_pattern_rows();
        set_config(64'h0000_0000_0043_4241, 64'd3, 64'd4);
        send_char(8'h41, 1'b0);
        send_char(8'h42, 1'b0);
        send_char(8'h43, 1'b0);
        send_char(8'h41, 1'b0);
        send_char(8'h42, 1'b0);
        send_char(8'h43, 1'b0);
        send_char(8'h41, 1'b0);
        send_char(8'h42, 1'b0);
        send_char(8'h43, 1'b1);
        wait_idle();
    endtask

    // clamped lengths, zero lengths, and a pattern longer than the row
    task automatic test_length_limits();
        // oversized codes clamp to 8 and 16; pattern carries both byte extremes
        set_config(64'hFF00_8040_2010_0801, 64'd15, 64'd31);
        send_char(8'h01, 1'b0);
        send_char(8'h08, 1'b0);
        send_char(8'h10, 1'b0);
        send_char(8'h20, 1'b0);
        send_char(8'h40, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        wait_idle();
        // row length zero acts as one, two character pattern never fits
        set_config(64'h0000_0000_0000_4141, 64'd2, 64'd0);
        send_char(8'h41, 1'b0);
        send_char(8'h41, 1'b1);
        wait_idle();
        // pattern length zero acts as one
        set_config(64'h0000_0000_0000_0041, 64'd0, 64'd16);
        send_char(8'h41, 1'b1);
        wait_idle();
    endtask

    // row length lowered while the text sits past the new last column
    task automatic test_row_shortened();
        set_config(64'h0000_0000_0000_0041, 64'd1, 64'd16);
        repeat (5) send_char(8'h42, 1'b0);
        wait_idle();
        set_config(64'h0000_0000_0000_0041, 64'd1, 64'd3);
        send_char(8'h42, 1'b0);
        send_char(8'h41, 1'b1);
        wait_idle();
    endtask

    // receiver holds off while the sender keeps offering, so the block backs up
    task automatic test_backpressure();
        int k;
        set_config(64'h0000_0000_0000_4241, 64'd2, 64'd6);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        rx_hold_request = 80;
        for (k = 0; k < 30; k++)
            send_char((k % 2 == 0) ? 8'h41 : 8'h42, k == 29);
        wait_idle();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // random configurations and texts built from a small alphabet with planted patterns
    task automatic test_random_texts();
        int sent;
        int text_len;
        int plen_eff;
        int k;
        int j;
        int r;
        int texts;
        bit open_end;
        logic [7:0]  alphabet [4];
        logic [7:0]  planted [$];
        logic [7:0]  c;
        logic [63:0] pattern;
        logic [63:0] plen_data;
        logic [63:0] rlen_data;
        sent = 0;
        while (sent < 820) begin
            for (k = 0; k < 4; k++)
                alphabet[k] = 8'($urandom_range(0, 255));
            for (k = 0; k < MAX_PATTERN_DEF; k++)
                pattern[8 * k +: 8] = alphabet[$urandom_range(0, 3)];
            // upper data bits are junk the block must ignore
            plen_data = {$urandom, $urandom};
            rlen_data = {$urandom, $urandom};
            r = $urandom_range(0, 9);
            plen_data[3:0] = (r == 0) ? 4'd0 :
                             (r == 1) ? 4'($urandom_range(9, 15)) :
                             (r == 2) ? 4'($urandom_range(5, 8)) : 4'($urandom_range(1, 4));
            r = $urandom_range(0, 9);
            rlen_data[4:0] = (r == 0) ? 5'd0 :
                             (r == 1) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(1, 16));
            set_config(pattern, plen_data, rlen_data);
            plen_eff = pat_len;
            if (plen_eff < 1)
                plen_eff = 1;
            if (plen_eff > MAX_PATTERN_DEF)
                plen_eff = MAX_PATTERN_DEF;
            // some phases run with no idling at all on one or both sides
            tx_idle_en = ($urandom_range(0, 2) != 0);
            rx_idle_en = ($urandom_range(0, 2) != 0);
            texts = $urandom_range(1, 3);
            for (j = 0; j < texts; j++) begin
                text_len = $urandom_range(1, 48);
                // now and then leave the text open across the next register change
                open_end = (j == texts - 1) && ($urandom_range(0, 3) == 0);
                planted.delete();
                for (k = 0; k < text_len; k++) begin
                    if (planted.size() == 0) begin
                        r = $urandom_range(0, 9);
                        if (r == 2)
                            for (int p = 0; p < plen_eff; p++)
                                planted.push_back(pattern[8 * p +: 8]);
                    end
                    if (planted.size() != 0)
                        c = planted.pop_front();
                    else if (r < 2)
                        c = 8'($urandom_range(0, 255));
                    else
                        c = alphabet[$urandom_range(0, 3)];
                    send_char(c, (k == text_len - 1) && !open_end);
                    sent++;
                end
            end
            wait_idle();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        rst_n <= 1'b0;
        text_if.valid <= 1'b0;
        text_if.ch <= '0;
        text_if.last_of_text <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_PATTERN_CHARS;
        cfg_if.data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_pattern_rows();
        test_length_limits();
        test_row_shortened();
        test_backpressure();
        test_random_texts();

        // everything drained by now; let the pipeline settle before the verdict
        wait_idle();
        repeat (4) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: row_pattern_matcher.f
+incdir+hdl
hdl/rpm_pkg.sv
hdl/rpm_ifs.sv
hdl/rpm_front.sv
hdl/rpm_queue.sv
hdl/rpm_back.sv
hdl/row_pattern_matcher.sv
tb/tb_top.sv
